@@ sv/lgd_pkg.sv @@
// package: shared constants, types and helpers of the light grid diffusion engine
`default_nettype none
package lgd_pkg;

    localparam int MAX_COLS_DEF = 256;
    localparam int MAX_ROWS_DEF = 256;

    localparam int CELL_W   = 24;
    localparam int ACTION_W = 3;
    localparam int COORD_W  = 8;
    localparam int POS_W    = 16;
    localparam int DISP_W   = 8;
    localparam int DIM_W    = 9;
    localparam int RADIUS_W = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [ACTION_W-1:0] ACT_READ      = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_POINT     = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_PROPAGATE = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_DISSIPATE = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_CLEAR     = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_COLS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd2;

    localparam logic [DIM_W-1:0]    COLS_RESET   = 9'd256;
    localparam logic [DIM_W-1:0]    ROWS_RESET   = 9'd256;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 8'd10;

    localparam logic [CELL_W-1:0] CELL_MAX      = 24'hFFFFFF;
    localparam logic [CELL_W-1:0] ONE_Q16       = 24'h010000;
    localparam logic [CELL_W-1:0] DISSIPATE_MUL = 24'd64881;

    typedef enum logic [4:0] {
        ST_WIPE,
        ST_IDLE,
        ST_CLR,
        ST_RD_ISSUE,
        ST_RD_DATA,
        ST_DS_RD,
        ST_DS_MUL,
        ST_DS_WR,
        ST_PL_R2,
        ST_PL_NUM,
        ST_PL_NUMC,
        ST_PL_ROW,
        ST_PL_ROWC,
        ST_PL_COL,
        ST_PL_DEN,
        ST_PL_DIV,
        ST_PL_WR,
        ST_PC_RD,
        ST_PC_WR,
        ST_PG_C,
        ST_PG_L,
        ST_PG_R,
        ST_PG_U,
        ST_PG_D,
        ST_PG_W,
        ST_FIN
    } state_t;

    function automatic logic [CELL_W-1:0] sat_add(input logic [CELL_W-1:0] a,
                                                  input logic [CELL_W-1:0] b);
        logic [CELL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CELL_W] ? CELL_MAX : s[CELL_W-1:0];
    endfunction

endpackage
`default_nettype wire

@@ sv/lgd_if.sv @@
// interfaces: command channel and result channel
`default_nettype none
interface lgd_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [lgd_pkg::ACTION_W-1:0]        action;
    logic [lgd_pkg::COORD_W-1:0]         cell_col;
    logic [lgd_pkg::COORD_W-1:0]         cell_row;
    logic signed [lgd_pkg::POS_W-1:0]    light_col;
    logic signed [lgd_pkg::POS_W-1:0]    light_row;
    logic [lgd_pkg::CELL_W-1:0]          light_intensity;

    modport source (output valid, action, cell_col, cell_row, light_col, light_row,
                    light_intensity, input ready);
    modport sink (input valid, action, cell_col, cell_row, light_col, light_row,
                  light_intensity, output ready);
endinterface

interface lgd_res_if;
    logic                         valid;
    logic                         ready;
    logic [lgd_pkg::CELL_W-1:0]   cell_level;
    logic [lgd_pkg::DISP_W-1:0]   display_level;
    logic                         done_res;

    modport source (output valid, cell_level, display_level, done_res, input ready);
    modport sink (input valid, cell_level, display_level, done_res, output ready);
endinterface
`default_nettype wire

@@ sv/light_grid_diffusion_engine_unit.sv @@
// top level: light grid store with a sequencer around one shared multiplier and divider
// read returns the cell; dissipate scales each cell; propagate copies the grid, then diffuses it
// point light works per row and per cell through the one-bit-per-cycle 40 step divider
// clear writes all MAX_COLS*MAX_ROWS store entries, one store write per cycle
// after reset all MAX_COLS*MAX_ROWS store entries are wiped; no command is taken meanwhile
// one command at a time; the result stays registered until taken
`default_nettype none
module light_grid_diffusion_engine_unit #(
    parameter int MAX_COLS = lgd_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = lgd_pkg::MAX_ROWS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    lgd_cmd_if.sink                                cmd,
    lgd_res_if.source                              res,
    input  wire logic                              cfg_wr_en,
    input  wire logic [lgd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [lgd_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CEW   = $clog2(MAX_COLS + 1);
    localparam int REW   = $clog2(MAX_ROWS + 1);
    localparam int LW    = 11;
    localparam int CELLW = lgd_pkg::CELL_W;
    localparam int NUM_W = 40;
    localparam int DEN_W = 36;
    localparam int SQ_W  = 34;
    localparam int CNT_W = $clog2(NUM_W + 1);

    lgd_pkg::state_t state_reg, state_next;

    logic [CELLW-1:0] light_mem [DEPTH];
    logic [CELLW-1:0] scratch_mem [DEPTH];
    logic [CELLW-1:0] light_rd_reg, scratch_rd_reg;
    logic             light_we, scratch_we;
    logic [AW-1:0]    light_wa, light_ra, scratch_ra;
    logic [CELLW-1:0] light_wd;

    logic [lgd_pkg::DIM_W-1:0]    cols_reg, rows_reg;
    logic [lgd_pkg::RADIUS_W-1:0] radius_reg;

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [AW-1:0] base_reg, base_next;
    logic [AW-1:0] sweep_reg, sweep_next;

    logic [lgd_pkg::COORD_W-1:0]      cell_col_reg, cell_row_reg;
    logic signed [lgd_pkg::POS_W-1:0] lc_reg, lr_reg;
    logic [CELLW-1:0]                 inten_reg;

    logic [15:0]        r2_reg, r2_next;
    logic [NUM_W-1:0]   num_reg, num_next;
    logic [SQ_W-1:0]    ady2_reg, ady2_next;
    logic [DEN_W-1:0]   den_reg, den_next;
    logic [DEN_W-1:0]   rem_reg, rem_next;
    logic [NUM_W-1:0]   dq_reg, dq_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CELLW-1:0]   acc_reg, acc_next;
    logic [2*CELLW-1:0] prod_reg;
    logic [CELLW-1:0]   mul_a, mul_b;

    logic                         out_valid_reg, out_valid_next;
    logic [CELLW-1:0]             level_reg, level_next;
    logic [lgd_pkg::DISP_W-1:0]   disp_reg, disp_next;

    logic [CEW-1:0] cols_eff;
    logic [REW-1:0] rows_eff;
    logic           last_col, last_row, grid_end;
    logic [AW-1:0]  cur_addr;
    logic           accept, in_range;
    logic [lgd_pkg::RADIUS_W-1:0] radius_eff;
    logic [17:0]    dx, dy;
    logic [16:0]    adx, ady;
    logic [DEN_W+1:0] trial;
    logic           borrow;
    logic [16:0]    clamp_lvl;
    logic [24:0]    disp_prod;
    logic [CELLW-1:0] q_clamped;
    logic [CELLW-1:0] quarter;

    // effective grid size and radius
    always_comb
    begin
        if (cols_reg == '0)
            cols_eff = CEW'(1);
        else if (LW'(cols_reg) > LW'(MAX_COLS))
            cols_eff = CEW'(MAX_COLS);
        else
            cols_eff = CEW'(cols_reg);
        if (rows_reg == '0)
            rows_eff = REW'(1);
        else if (LW'(rows_reg) > LW'(MAX_ROWS))
            rows_eff = REW'(MAX_ROWS);
        else
            rows_eff = REW'(rows_reg);
        radius_eff = (radius_reg == '0) ? lgd_pkg::RADIUS_W'(1) : radius_reg;
    end

    assign last_col = (col_reg == CW'(cols_eff - CEW'(1)));
    assign last_row = (row_reg == RW'(rows_eff - REW'(1)));
    assign grid_end = last_col && last_row;
    assign cur_addr = base_reg + AW'(col_reg);
    assign accept   = cmd.valid && cmd.ready;
    assign in_range = (LW'(cell_col_reg) < LW'(cols_eff)) && (LW'(cell_row_reg) < LW'(rows_eff));

    assign dx  = {{2{lc_reg[15]}}, lc_reg} - 18'({1'b0, col_reg});
    assign dy  = {{2{lr_reg[15]}}, lr_reg} - 18'({1'b0, row_reg});
    assign adx = dx[17] ? 17'(-dx) : dx[16:0];
    assign ady = dy[17] ? 17'(-dy) : dy[16:0];

    assign trial  = {1'b0, rem_reg, dq_reg[NUM_W-1]} - {2'b0, den_reg};
    assign borrow = trial[DEN_W+1];

    assign clamp_lvl = (light_rd_reg > lgd_pkg::ONE_Q16) ? 17'h10000 : light_rd_reg[16:0];
    assign disp_prod = {clamp_lvl, 8'b0} - 25'(clamp_lvl);
    assign q_clamped = (|dq_reg[NUM_W-1:CELLW]) ? lgd_pkg::CELL_MAX : dq_reg[CELLW-1:0];
    assign quarter   = scratch_rd_reg >> 2;

    assign cmd.ready         = (state_reg == lgd_pkg::ST_IDLE) && !out_valid_reg;
    assign res.valid         = out_valid_reg;
    assign res.cell_level    = level_reg;
    assign res.display_level = disp_reg;
    assign res.done_res      = 1'b1;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        base_next      = base_reg;
        sweep_next     = sweep_reg;
        r2_next        = r2_reg;
        num_next       = num_reg;
        ady2_next      = ady2_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        dq_next        = dq_reg;
        cnt_next       = cnt_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && !res.ready;
        level_next     = level_reg;
        disp_next      = disp_reg;
        mul_a          = '0;
        mul_b          = '0;
        light_we       = 1'b0;
        light_wa       = cur_addr;
        light_wd       = '0;
        light_ra       = cur_addr;
        scratch_we     = 1'b0;
        scratch_ra     = cur_addr;

        unique case (state_reg) inside
            lgd_pkg::ST_WIPE, lgd_pkg::ST_CLR:
            begin
                light_we   = 1'b1;
                light_wa   = sweep_reg;
                sweep_next = sweep_reg + AW'(1);
                if (sweep_reg == AW'(DEPTH - 1))
                    state_next = (state_reg == lgd_pkg::ST_WIPE) ? lgd_pkg::ST_IDLE
                                                                 : lgd_pkg::ST_FIN;
            end
            lgd_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    level_next = '0;
                    disp_next  = '0;
                    col_next   = '0;
                    row_next   = '0;
                    base_next  = '0;
                    sweep_next = '0;
                    case (cmd.action)
                        lgd_pkg::ACT_READ:      state_next = lgd_pkg::ST_RD_ISSUE;
                        lgd_pkg::ACT_POINT:     state_next = lgd_pkg::ST_PL_R2;
                        lgd_pkg::ACT_PROPAGATE: state_next = lgd_pkg::ST_PC_RD;
                        lgd_pkg::ACT_DISSIPATE: state_next = lgd_pkg::ST_DS_RD;
                        lgd_pkg::ACT_CLEAR:     state_next = lgd_pkg::ST_CLR;
                        default:                state_next = lgd_pkg::ST_FIN;
                    endcase
                end
            end
            lgd_pkg::ST_RD_ISSUE:
            begin
                light_ra   = AW'(AW'(cell_row_reg) * AW'(MAX_COLS)) + AW'(cell_col_reg);
                state_next = lgd_pkg::ST_RD_DATA;
            end
            lgd_pkg::ST_RD_DATA:
            begin
                if (in_range)
                begin
                    level_next = light_rd_reg;
                    disp_next  = disp_prod[23:16];
                end
                state_next = lgd_pkg::ST_FIN;
            end
            lgd_pkg::ST_DS_RD:
            begin
                state_next = lgd_pkg::ST_DS_MUL;
            end
            lgd_pkg::ST_DS_MUL:
            begin
                mul_a      = light_rd_reg;
                mul_b      = lgd_pkg::DISSIPATE_MUL;
                state_next = lgd_pkg::ST_DS_WR;
            end
            lgd_pkg::ST_DS_WR:
            begin
                light_we   = 1'b1;
                light_wd   = prod_reg[CELLW+15:16];
                state_next = lgd_pkg::ST_DS_RD;
            end
            lgd_pkg::ST_PL_R2:
            begin
                mul_a      = CELLW'(radius_eff);
                mul_b      = CELLW'(radius_eff);
                state_next = lgd_pkg::ST_PL_NUM;
            end
            lgd_pkg::ST_PL_NUM:
            begin
                r2_next    = prod_reg[15:0];
                mul_a      = inten_reg;
                mul_b      = CELLW'(prod_reg[15:0]);
                state_next = lgd_pkg::ST_PL_NUMC;
            end
            lgd_pkg::ST_PL_NUMC:
            begin
                num_next   = prod_reg[NUM_W-1:0];
                state_next = lgd_pkg::ST_PL_ROW;
            end
            lgd_pkg::ST_PL_ROW:
            begin
                mul_a      = CELLW'(ady);
                mul_b      = CELLW'(ady);
                state_next = lgd_pkg::ST_PL_ROWC;
            end
            lgd_pkg::ST_PL_ROWC:
            begin
                ady2_next  = prod_reg[SQ_W-1:0];
                state_next = lgd_pkg::ST_PL_COL;
            end
            lgd_pkg::ST_PL_COL:
            begin
                mul_a      = CELLW'(adx);
                mul_b      = CELLW'(adx);
                state_next = lgd_pkg::ST_PL_DEN;
            end
            lgd_pkg::ST_PL_DEN:
            begin
                den_next   = DEN_W'(r2_reg) + DEN_W'(ady2_reg) + DEN_W'(prod_reg[SQ_W-1:0]);
                rem_next   = '0;
                dq_next    = num_reg;
                cnt_next   = CNT_W'(NUM_W);
                state_next = lgd_pkg::ST_PL_DIV;
            end
            lgd_pkg::ST_PL_DIV:
            begin
                rem_next = borrow ? {rem_reg[DEN_W-2:0], dq_reg[NUM_W-1]} : trial[DEN_W-1:0];
                dq_next  = {dq_reg[NUM_W-2:0], !borrow};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                    state_next = lgd_pkg::ST_PL_WR;
            end
            lgd_pkg::ST_PL_WR:
            begin
                light_we   = 1'b1;
                light_wd   = lgd_pkg::sat_add(light_rd_reg, q_clamped);
                state_next = last_col ? lgd_pkg::ST_PL_ROW : lgd_pkg::ST_PL_COL;
            end
            lgd_pkg::ST_PC_RD:
            begin
                state_next = lgd_pkg::ST_PC_WR;
            end
            lgd_pkg::ST_PC_WR:
            begin
                scratch_we = 1'b1;
                state_next = lgd_pkg::ST_PC_RD;
            end
            lgd_pkg::ST_PG_C:
            begin
                state_next = lgd_pkg::ST_PG_L;
            end
            lgd_pkg::ST_PG_L:
            begin
                scratch_ra = (col_reg != '0) ? cur_addr - AW'(1) : cur_addr;
                acc_next   = scratch_rd_reg & CELLW'(3);
                state_next = lgd_pkg::ST_PG_R;
            end
            lgd_pkg::ST_PG_R:
            begin
                scratch_ra = !last_col ? cur_addr + AW'(1) : cur_addr;
                if (col_reg != '0)
                    acc_next = lgd_pkg::sat_add(acc_reg, quarter);
                state_next = lgd_pkg::ST_PG_U;
            end
            lgd_pkg::ST_PG_U:
            begin
                scratch_ra = (row_reg != '0) ? cur_addr - AW'(MAX_COLS) : cur_addr;
                if (!last_col)
                    acc_next = lgd_pkg::sat_add(acc_reg, quarter);
                state_next = lgd_pkg::ST_PG_D;
            end
            lgd_pkg::ST_PG_D:
            begin
                scratch_ra = !last_row ? cur_addr + AW'(MAX_COLS) : cur_addr;
                if (row_reg != '0)
                    acc_next = lgd_pkg::sat_add(acc_reg, quarter);
                state_next = lgd_pkg::ST_PG_W;
            end
            lgd_pkg::ST_PG_W:
            begin
                light_we   = 1'b1;
                light_wd   = !last_row ? lgd_pkg::sat_add(acc_reg, quarter) : acc_reg;
                state_next = lgd_pkg::ST_PG_C;
            end
            lgd_pkg::ST_FIN:
            begin
                out_valid_next = 1'b1;
                state_next     = lgd_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = lgd_pkg::ST_IDLE;
            end
        endcase

        // cell walk advance after each per-cell write
        if (state_reg == lgd_pkg::ST_DS_WR || state_reg == lgd_pkg::ST_PL_WR ||
            state_reg == lgd_pkg::ST_PC_WR || state_reg == lgd_pkg::ST_PG_W)
        begin
            if (grid_end)
            begin
                col_next  = '0;
                row_next  = '0;
                base_next = '0;
                state_next = (state_reg == lgd_pkg::ST_PC_WR) ? lgd_pkg::ST_PG_C
                                                              : lgd_pkg::ST_FIN;
            end
            else if (last_col)
            begin
                col_next  = '0;
                row_next  = row_reg + RW'(1);
                base_next = base_reg + AW'(MAX_COLS);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lgd_pkg::ST_WIPE;
            col_reg       <= '0;
            row_reg       <= '0;
            base_reg      <= '0;
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
            cols_reg      <= lgd_pkg::COLS_RESET;
            rows_reg      <= lgd_pkg::ROWS_RESET;
            radius_reg    <= lgd_pkg::RADIUS_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            base_reg      <= base_next;
            sweep_reg     <= sweep_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    lgd_pkg::REG_COLS:   cols_reg   <= cfg_data;
                    lgd_pkg::REG_ROWS:   rows_reg   <= cfg_data;
                    lgd_pkg::REG_RADIUS: radius_reg <= cfg_data[lgd_pkg::RADIUS_W-1:0];
                    default:             ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cell_col_reg <= cmd.cell_col;
            cell_row_reg <= cmd.cell_row;
            lc_reg       <= cmd.light_col;
            lr_reg       <= cmd.light_row;
            inten_reg    <= cmd.light_intensity;
        end
        r2_reg    <= r2_next;
        num_reg   <= num_next;
        ady2_reg  <= ady2_next;
        den_reg   <= den_next;
        rem_reg   <= rem_next;
        dq_reg    <= dq_next;
        cnt_reg   <= cnt_next;
        acc_reg   <= acc_next;
        prod_reg  <= mul_a * mul_b;
        level_reg <= level_next;
        disp_reg  <= disp_next;
    end

    // light store
    always_ff @(posedge clk)
    begin
        if (light_we)
            light_mem[light_wa] <= light_wd;
        light_rd_reg <= light_mem[light_ra];
    end

    // old grid copy for diffusion
    always_ff @(posedge clk)
    begin
        if (scratch_we)
            scratch_mem[cur_addr] <= light_rd_reg;
        scratch_rd_reg <= scratch_mem[scratch_ra];
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |=> !cmd.ready)
        else $error("command taken while busy");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lgd_pkg::ST_IDLE) |-> !(light_we || scratch_we))
        else $error("store written while idle");

    a_disp_full: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> ((res.display_level == 8'hFF) == (res.cell_level >= lgd_pkg::ONE_Q16)))
        else $error("display level does not match cell level");

endmodule
`default_nettype wire
